@@ design/pag_pkg.sv @@
`timescale 1ns / 1ps
package pag_pkg;
   localparam int LOG_TABLE_BITS = 8;
   localparam int TABLE_SIZE = 1 << LOG_TABLE_BITS;
   localparam logic [5:0] MAX_EVENTS = 6'd63;
   localparam logic [15:0] COUNT_LIMIT = 16'd65535;
   localparam logic [30:0] LCG_MOD = 31'h7FFFFFFF;
   localparam logic [14:0] LCG_MULT = 15'd16807;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [31:0] MEAN_RESET = 32'd65536;
   localparam logic [30:0] SEED_RESET = 31'd12345;
   localparam logic CSR_MEAN = 1'b0;
   localparam logic CSR_SEED = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [31:0] window_time;
      logic [5:0]  event_total;
   } cmd_type;

   typedef struct packed {
      logic [5:0]  event_index;
      logic [31:0] wait_time;
      logic [31:0] arrival_time;
      logic [15:0] event_count;
      logic        count_saturated;
      logic        last;
   } rsp_type;

   function automatic logic [15:0] log2_frac(input int i);
      logic [63:0] x;
      logic [15:0] r;
      x = 64'(TABLE_SIZE + i) << (30 - LOG_TABLE_BITS);
      r = '0;
      for (int b = 15; b >= 0; b--) begin
         x = (x * x) >> 30;
         if (x >= (64'd2 << 30)) begin
            x = x >> 1;
            r[b] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [30:0] sanitize_seed(input logic [30:0] s);
      if (s == '0 || s == LCG_MOD) return 31'd1;
      return s;
   endfunction
endpackage

@@ design/poisson_arrival_generator_top.sv @@
`timescale 1ns / 1ps
// Each drawn wait passes through six steps in order (multiply, mod fold, log lookup,
// ln2 scale, mean scale, accumulate); each result is then issued from the output state.
// Kind 1 draws event_total waits; kind 0 draws until the window is reached, up to
// 65535 draws. The single shared draw sequencer takes one command at a time.
// Reset: synchronous, active high; clears queues, loads seed 12345 and mean 1.0.
module poisson_arrival_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_kind,
   input  logic [31:0] req_window_time,
   input  logic [5:0]  req_event_total,
   output logic        empty,
   input  logic        pop,
   output logic [5:0]  rsp_event_index,
   output logic [31:0] rsp_wait_time,
   output logic [31:0] rsp_arrival_time,
   output logic [15:0] rsp_event_count,
   output logic        rsp_count_saturated,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import pag_pkg::*;
   cmd_type cmd;
   rsp_type rsp;
   logic cmd_valid, cmd_take, rsp_valid, seed_load;
   logic [31:0] mean_ff;

   assign csr_ready = 1'b1;
   assign seed_load = csr_valid && csr_index == CSR_SEED;
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= MEAN_RESET;
      end else if (csr_valid && csr_index == CSR_MEAN) begin
         mean_ff <= csr_data;
      end
   end

   pag_front u_front (.clock, .reset, .req_push(push), .full, .req_kind,
      .req_window_time, .req_event_total, .cmd, .cmd_valid, .cmd_take);
   pag_back u_back (.clock, .reset, .cmd, .cmd_valid, .cmd_take,
      .mean_interval(mean_ff), .seed_load, .seed_value(csr_data[30:0]),
      .rsp, .rsp_valid, .rsp_take(pop));

   assign empty = !rsp_valid;
   assign rsp_event_index = rsp.event_index;
   assign rsp_wait_time = rsp.wait_time;
   assign rsp_arrival_time = rsp.arrival_time;
   assign rsp_event_count = rsp.event_count;
   assign rsp_count_saturated = rsp.count_saturated;
   assign rsp_last = rsp.last;
endmodule

@@ design/pag_front.sv @@
`timescale 1ns / 1ps
module pag_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             full,
   input  logic             req_kind,
   input  logic [31:0]      req_window_time,
   input  logic [5:0]       req_event_total,
   output pag_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_take
);
   import pag_pkg::*;
   // two-entry command queue; clamp event_total on entry
   cmd_type q_ff [2];
   cmd_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic push_ok;
   assign full = cnt_ff == 2'd2;
   assign push_ok = req_push && !full;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd = q_ff[rd_ff];
   always_comb begin
      q_in.kind = req_kind;
      q_in.window_time = req_window_time;
      q_in.event_total = (req_event_total > MAX_EVENTS) ? MAX_EVENTS : req_event_total;
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, cmd_take};
      wr_in = wr_ff ^ push_ok;
      rd_in = rd_ff ^ cmd_take;
   end
   always_ff @(posedge clock) begin
      if (push_ok) q_ff[wr_ff] <= q_in;
      if (reset) begin
         cnt_ff <= '0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end
endmodule

@@ design/pag_back.sv @@
`timescale 1ns / 1ps
module pag_back (
   input  logic             clock,
   input  logic             reset,
   input  pag_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  logic [31:0]      mean_interval,
   input  logic             seed_load,
   input  logic [30:0]      seed_value,
   output pag_pkg::rsp_type rsp,
   output logic             rsp_valid,
   input  logic             rsp_take
);
   import pag_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_MOD = 3'd2, S_LOG = 3'd3,
      S_LN = 3'd4, S_SCL = 3'd5, S_ACC = 3'd6, S_OUT = 3'd7;

   logic [15:0] log_rom [TABLE_SIZE];
   always_comb for (int i = 0; i < TABLE_SIZE; i++) log_rom[i] = log2_frac(i);

   logic [2:0]  st_ff, st_in;
   cmd_type     c_ff, c_in;
   logic [30:0] x_ff, x_in;
   logic [45:0] p_ff, p_in;
   logic [20:0] g_ff, g_in;
   logic [31:0] nl_ff, nl_in;
   logic [63:0] w_ff, w_in;
   logic [31:0] t_ff, t_in;
   logic [15:0] n_ff, n_in;
   logic [5:0]  i_ff, i_in;
   logic [31:0] lw_ff, lw_in;
   rsp_type     r_ff, r_in;
   logic        v_ff, v_in;
   logic [31:0] mod1;
   logic [31:0] mod2;
   logic [4:0]  pos;
   logic [LOG_TABLE_BITS-1:0] f;
   logic [52:0] lnp;
   logic [32:0] ts;
   logic [31:0] wsat;
   logic        stop;

   assign rsp = r_ff;
   assign rsp_valid = v_ff;

   always_comb begin
      st_in = st_ff; c_in = c_ff; x_in = x_ff; p_in = p_ff; g_in = g_ff;
      nl_in = nl_ff; w_in = w_ff; t_in = t_ff; n_in = n_ff; i_in = i_ff;
      lw_in = lw_ff; r_in = r_ff; v_in = v_ff && !rsp_take; cmd_take = 1'b0;
      mod1 = {1'b0, p_ff[30:0]} + {17'b0, p_ff[45:31]};
      mod2 = (mod1 >= {1'b0, LCG_MOD}) ? mod1 - {1'b0, LCG_MOD} : mod1;
      pos = '0;
      for (int b = 0; b < 31; b++) if (x_ff[b]) pos = 5'(b);
      f = LOG_TABLE_BITS'(({x_ff, {LOG_TABLE_BITS{1'b0}}} >> pos));
      lnp = 53'(g_ff) * 53'(LN2_Q32) + 53'h80000000;
      wsat = (w_ff[63:48] != '0) ? 32'hFFFFFFFF : w_ff[47:16];
      ts = {1'b0, t_ff} + {1'b0, wsat};
      stop = 1'b0;
      case (st_ff)
         S_IDLE: if (cmd_valid) begin
            c_in = cmd; cmd_take = 1'b1; t_in = '0; n_in = '0; i_in = '0; lw_in = '0;
            if (cmd.kind) st_in = S_OUT;
            else if (cmd.window_time == '0) st_in = S_OUT;
            else st_in = S_MUL;
         end
         S_MUL: begin p_in = 46'(x_ff) * 46'(LCG_MULT); st_in = S_MOD; end
         S_MOD: begin
            x_in = (mod2[30:0] == '0) ? 31'd1 : mod2[30:0];
            st_in = S_LOG;
         end
         S_LOG: begin
            g_in = 21'(31 * 65536) - {pos, 16'b0} - {5'b0, log_rom[f]};
            st_in = S_LN;
         end
         S_LN: begin nl_in = 32'(lnp[52:32]);
            st_in = S_SCL; end
         S_SCL: begin w_in = 64'(nl_ff) * 64'(mean_interval) + 64'h8000; st_in = S_ACC; end
         S_ACC: begin
            lw_in = wsat;
            t_in = ts[32] ? 32'hFFFFFFFF : ts[31:0];
            n_in = n_ff + 16'd1;
            if (c_ff.kind) begin
               i_in = i_ff + 6'd1; st_in = S_OUT;
            end else if (t_in < c_ff.window_time && n_in < COUNT_LIMIT) st_in = S_MUL;
            else st_in = S_OUT;
         end
         S_OUT: if (!v_ff || rsp_take) begin
            v_in = 1'b1;
            r_in.event_index = c_ff.kind ? i_ff : 6'd0;
            r_in.wait_time = lw_ff;
            r_in.arrival_time = t_ff;
            r_in.event_count = c_ff.kind ? 16'd0 : n_ff;
            r_in.count_saturated = !c_ff.kind && n_ff >= COUNT_LIMIT
               && t_ff < c_ff.window_time;
            stop = !c_ff.kind || i_ff == c_ff.event_total;
            r_in.last = stop;
            st_in = stop ? S_IDLE : S_MUL;
         end
         default: st_in = S_IDLE;
      endcase
      if (seed_load) x_in = sanitize_seed(seed_value);
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in; p_ff <= p_in; g_ff <= g_in; nl_ff <= nl_in; w_ff <= w_in;
      t_ff <= t_in; n_ff <= n_in; i_ff <= i_in; lw_ff <= lw_in; r_ff <= r_in;
      if (reset) begin
         st_ff <= S_IDLE; v_ff <= 1'b0; x_ff <= sanitize_seed(SEED_RESET);
      end else begin
         st_ff <= st_in; v_ff <= v_in; x_ff <= x_in;
      end
   end
endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import pag_pkg::*;

   class arrival_scoreboard;
      logic [31:0] mean;
      logic [30:0] seed_reg;
      logic [30:0] lehmer;
      logic [15:0] frac_tbl [TABLE_SIZE];
      rsp_type     pending_q [$];
      int          errors;
      int          requests;
      int          results;
      int          reg_writes;

      function new();
         logic [63:0] x;
         logic [15:0] r;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            // Square in Q1.30, one result bit per step
            x = 64'(TABLE_SIZE + i) << (30 - LOG_TABLE_BITS);
            r = '0;
            for (int b = 15; b >= 0; b--) begin
               x = (x * x) >> 30;
               if (x >= 64'h8000_0000) begin
                  x = x >> 1;
                  r[b] = 1'b1;
               end
            end
            frac_tbl[i] = r;
         end
         mean = MEAN_RESET;
         seed_reg = SEED_RESET;
         lehmer = SEED_RESET;
         errors = 0;
         requests = 0;
         results = 0;
         reg_writes = 0;
      endfunction

      function void write_reg(logic idx, logic [31:0] data);
         reg_writes++;
         if (idx == CSR_MEAN) begin
            mean = data;
         end else begin
            seed_reg = data[30:0];
            if (seed_reg == '0 || seed_reg == LCG_MOD) lehmer = 31'd1;
            else lehmer = seed_reg;
         end
      endfunction

      function logic [31:0] next_wait();
         logic [63:0] p;
         logic [63:0] g;
         logic [63:0] nl;
         logic [63:0] w;
         int          pos;
         int unsigned f;
         p = 64'(lehmer) * 64'(LCG_MULT);
         lehmer = 31'(p % 64'h7FFF_FFFF);
         if (lehmer == '0) lehmer = 31'd1;
         pos = 0;
         for (int b = 0; b <= 30; b++)
            if (lehmer[b]) pos = b;
         if (pos >= LOG_TABLE_BITS)
            f = (32'(lehmer) >> (pos - LOG_TABLE_BITS)) & (TABLE_SIZE - 1);
         else
            f = (32'(lehmer) << (LOG_TABLE_BITS - pos)) & (TABLE_SIZE - 1);
         g = 64'd31 * 64'd65536 - (64'(pos) * 64'd65536 + 64'(frac_tbl[f]));
         nl = (g * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
         w = (nl * 64'(mean) + 64'h8000) >> 16;
         if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
         return w[31:0];
      endfunction

      function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
         logic [32:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[32] ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      function void note_request(cmd_type c);
         rsp_type     e;
         logic [31:0] t;
         logic [31:0] w;
         logic [15:0] n;
         logic [5:0]  total;
         requests++;
         t = '0;
         w = '0;
         n = '0;
         if (c.kind == 1'b0) begin
            while (t < c.window_time && n < COUNT_LIMIT) begin
               w = next_wait();
               n++;
               t = add_sat(t, w);
            end
            e.event_index = '0;
            e.wait_time = w;
            e.arrival_time = t;
            e.event_count = n;
            e.count_saturated = (n >= COUNT_LIMIT) && (t < c.window_time);
            e.last = 1'b1;
            pending_q.push_back(e);
         end else begin
            total = (c.event_total > MAX_EVENTS) ? MAX_EVENTS : c.event_total;
            for (int i = 0; i <= total; i++) begin
               w = '0;
               if (i > 0) begin
                  w = next_wait();
                  t = add_sat(t, w);
               end
               e.event_index = 6'(i);
               e.wait_time = w;
               e.arrival_time = t;
               e.event_count = '0;
               e.count_saturated = 1'b0;
               e.last = (i == total);
               pending_q.push_back(e);
            end
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         results++;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result idx=%0d wait=%h arr=%h cnt=%0d sat=%b last=%b",
                        got.event_index, got.wait_time, got.arrival_time,
                        got.event_count, got.count_saturated, got.last);
            return;
         end
         e = pending_q.pop_front();
         if (got !== e) begin
            errors++;
            if (errors <= 10)
               $display("mismatch exp idx=%0d wait=%h arr=%h cnt=%0d sat=%b last=%b / got idx=%0d wait=%h arr=%h cnt=%0d sat=%b last=%b",
                        e.event_index, e.wait_time, e.arrival_time, e.event_count,
                        e.count_saturated, e.last, got.event_index, got.wait_time,
                        got.arrival_time, got.event_count, got.count_saturated, got.last);
         end
      endfunction
   endclass

   localparam int IDLE_LIMIT = 1600000;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic        req_kind;
   logic [31:0] req_window_time;
   logic [5:0]  req_event_total;
   logic        empty;
   logic        pop;
   logic [5:0]  rsp_event_index;
   logic [31:0] rsp_wait_time;
   logic [31:0] rsp_arrival_time;
   logic [15:0] rsp_event_count;
   logic        rsp_count_saturated;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;

   arrival_scoreboard sb = new();
   logic rx_hold = 1'b0;
   logic no_idle = 1'b0;
   int   idle_cycles = 0;
   int   full_seen = 0;

   poisson_arrival_generator_top uut (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Caller stands at a falling edge; returns at a falling edge.
   task automatic send_request(logic kind, logic [31:0] window, logic [5:0] total);
      cmd_type c;
      int      gap;
      c.kind = kind;
      c.window_time = window;
      c.event_total = total;
      req_kind = kind;
      req_window_time = window;
      req_event_total = total;
      push = 1'b1;
      do begin
         @(posedge clock);
         if (full) full_seen++;
      end while (full);
      sb.note_request(c);
      @(negedge clock);
      gap = gap_len();
      if (gap > 0) begin
         push = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_reg(logic idx, logic [31:0] data);
      push = 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      // let any trailing draw settle before touching registers
      repeat (30) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] pick_window(logic [31:0] m);
      logic [63:0] v;
      if (m >= 32'h1000_0000) return $urandom;
      v = 64'(m) * 64'($urandom_range(0, 12)) + 64'($urandom_range(0, m));
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      return v[31:0];
   endfunction

   // Result side: decide pop at the falling edge
   initial begin
      bit held;
      held = 1'b0;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold && !held) begin
            held = 1'b1;
            pop = 1'b0;
            repeat (3000) @(negedge clock);
         end else if (!no_idle && $urandom_range(0, 199) == 0) begin
            pop = 1'b0;
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end else begin
            pop = no_idle || ($urandom_range(0, 99) < 70);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && pop && !empty) begin
         got.event_index = rsp_event_index;
         got.wait_time = rsp_wait_time;
         got.arrival_time = rsp_arrival_time;
         got.event_count = rsp_event_count;
         got.count_saturated = rsp_count_saturated;
         got.last = rsp_last;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [31:0] m;
      reset = 1'b1;
      push = 1'b0;
      req_kind = 1'b0;
      req_window_time = '0;
      req_event_total = '0;
      csr_valid = 1'b0;
      csr_index = CSR_MEAN;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: window extremes, arrival count extremes, seed and mean corners
      send_request(1'b0, 32'd0, 6'd0);
      send_request(1'b0, 32'd1, 6'd63);
      send_request(1'b0, 32'h0005_0000, 6'd0);
      send_request(1'b1, 32'hFFFF_FFFF, 6'd0);
      send_request(1'b1, 32'd0, 6'd63);
      send_request(1'b1, 32'd0, 6'd1);
      write_reg(CSR_SEED, 32'd0);
      send_request(1'b1, 32'd0, 6'd3);
      write_reg(CSR_SEED, 32'hFFFF_FFFF);
      send_request(1'b1, 32'd0, 6'd3);
      write_reg(CSR_SEED, 32'd2147483646);
      send_request(1'b0, 32'h0003_0000, 6'd0);
      write_reg(CSR_MEAN, 32'hFFFF_FFFF);
      send_request(1'b0, 32'hFFFF_FFFF, 6'd0);
      send_request(1'b1, 32'd0, 6'd5);
      write_reg(CSR_MEAN, 32'd0);
      send_request(1'b1, 32'd0, 6'd4);
      // zero mean: count runs to the limit
      send_request(1'b0, 32'd1, 6'd0);
      write_reg(CSR_MEAN, 32'd1);
      write_reg(CSR_SEED, 32'd1);
      send_request(1'b0, 32'd20, 6'd0);
      send_request(1'b1, 32'd0, 6'd2);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: m = MEAN_RESET;
            1: m = 32'hFFFF_FFFF;
            2: m = 32'd1;
            3: m = $urandom_range(32'h100, 32'h10_0000);
            4: m = $urandom_range(1, 32'h0FFF_FFFF);
            default: m = $urandom;
         endcase
         if (m == 0) m = 32'd1;
         write_reg(CSR_MEAN, m);
         if (ph % 2 == 0) write_reg(CSR_SEED, $urandom);
         else write_reg(CSR_SEED, $urandom_range(1, 2147483646));
         no_idle = (ph == 3);
         // hold the result side off so the block backs up
         if (ph == 1) rx_hold = 1'b1;
         for (int k = 0; k < 42; k++) begin
            if ($urandom_range(0, 99) < 40)
               send_request(1'b0, pick_window(m), 6'($urandom));
            else if ($urandom_range(0, 99) < 70)
               send_request(1'b1, $urandom, 6'($urandom_range(0, 8)));
            else
               send_request(1'b1, $urandom, 6'($urandom_range(0, 63)));
         end
      end
      push = 1'b0;
      no_idle = 1'b0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d requests, %0d results, %0d register writes",
               sb.requests, sb.results, sb.reg_writes);
      $display("input stalled by full on %0d cycles, %0d mismatches", full_seen, sb.errors);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

@@ files.f @@
design/pag_pkg.sv
design/pag_front.sv
design/pag_back.sv
design/poisson_arrival_generator_top.sv
tb/sv/tb_top.sv
